### sv/dfir_pkg.sv
package dfir_pkg;

    localparam int SAMPLE_WIDTH   = 16;
    localparam int MAX_TAPS       = 64;
    localparam int MAX_DECIMATION = 256;
    localparam int TAP_AW         = $clog2(MAX_TAPS);
    localparam int PHASE_W        = 8;
    localparam int DIGIT_W        = 4;
    localparam int N_DIGITS       = SAMPLE_WIDTH / DIGIT_W;
    localparam int DIG_AW         = $clog2(N_DIGITS);
    localparam int ACC_W          = 2 * SAMPLE_WIDTH + TAP_AW;

    localparam int TAPCNT_W = 7;
    localparam int DEC_W    = 9;
    localparam int MODE_W   = 2;
    localparam int CFG_AW   = 2;
    localparam int CFG_DW   = 9;

    localparam logic [CFG_AW-1:0] CFG_TAP_COUNT    = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_DECIMATION   = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_CHANNEL_MODE = 2'd2;

    localparam logic [MODE_W-1:0] MODE_COMPLEX = 2'd0;
    localparam logic [MODE_W-1:0] MODE_I_ONLY  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_Q_ONLY  = 2'd2;

    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_LOAD = 1'b1;

    typedef struct packed {
        logic                           action;
        logic [5:0]                     tap_index;
        logic signed [SAMPLE_WIDTH-1:0] coef_i;
        logic signed [SAMPLE_WIDTH-1:0] coef_q;
        logic signed [SAMPLE_WIDTH-1:0] sample_i;
        logic signed [SAMPLE_WIDTH-1:0] sample_q;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] out_i;
        logic signed [SAMPLE_WIDTH-1:0] out_q;
    } t_out_item;

    typedef struct packed {
        logic              clr;
        logic              load;
        logic              step;
        logic [DIG_AW-1:0] dig;
    } t_mac_ctl;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_LOAD,
        S_MAC,
        S_DONE
    } t_state;

endpackage

### sv/dfir_store.sv
module dfir_store
    import dfir_pkg::*;
(
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_we,
    input  logic [TAP_AW-1:0]              i_waddr,
    input  logic signed [SAMPLE_WIDTH-1:0] i_wdata,
    input  logic [TAP_AW-1:0]              i_raddr,
    output logic signed [SAMPLE_WIDTH-1:0] o_rdata
);

    logic signed [SAMPLE_WIDTH-1:0] r_mem [MAX_TAPS];
    logic [MAX_TAPS-1:0]            r_vld;
    logic signed [SAMPLE_WIDTH-1:0] r_rd;

    // Entries that were never written since reset read as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_we) begin
            r_vld[i_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rd <= r_vld[i_raddr] ? r_mem[i_raddr] : '0;
    end

    assign o_rdata = r_rd;

endmodule

### sv/dfir_mac.sv
module dfir_mac
    import dfir_pkg::*;
(
    input  logic                           i_clk,
    input  t_mac_ctl                       i_ctl,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    input  logic signed [SAMPLE_WIDTH-1:0] i_coef,
    output logic signed [SAMPLE_WIDTH-1:0] o_result
);

    localparam int QW = ACC_W - SAMPLE_WIDTH + 1;
    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (SAMPLE_WIDTH - 2);
    localparam logic signed [QW-1:0] Q_HI = QW'((1 << (SAMPLE_WIDTH - 1)) - 1);
    localparam logic signed [QW-1:0] Q_LO = -Q_HI - QW'(1);

    logic signed [SAMPLE_WIDTH-1:0]     r_smp;
    logic [SAMPLE_WIDTH-1:0]            r_coef;
    logic signed [ACC_W-1:0]            r_acc;
    logic signed [DIGIT_W:0]            w_digit;
    logic signed [SAMPLE_WIDTH+DIGIT_W:0] w_prod;
    logic signed [ACC_W-1:0]            w_term;
    logic signed [ACC_W-1:0]            w_sum;
    logic signed [QW-1:0]               w_q;

    // The top digit of the coefficient carries its sign; the others are unsigned.
    always_comb begin
        w_digit = {(i_ctl.dig == DIG_AW'(N_DIGITS - 1)) & r_coef[DIGIT_W-1],
                   r_coef[DIGIT_W-1:0]};
        w_prod  = r_smp * w_digit;
        w_term  = ACC_W'(w_prod) <<< (int'(i_ctl.dig) * DIGIT_W);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.clr) begin
            r_acc <= '0;
        end else if (i_ctl.step) begin
            r_acc <= r_acc + w_term;
        end
        if (i_ctl.load) begin
            r_smp  <= i_sample;
            r_coef <= i_coef;
        end else if (i_ctl.step) begin
            r_coef <= r_coef >> DIGIT_W;
        end
    end

    // Round half up from Q8.30 to Q1.15, then saturate.
    always_comb begin
        w_sum = r_acc + HALF;
        w_q   = w_sum[ACC_W-1:SAMPLE_WIDTH-1];
        if (w_q > Q_HI) begin
            o_result = Q_HI[SAMPLE_WIDTH-1:0];
        end else if (w_q < Q_LO) begin
            o_result = Q_LO[SAMPLE_WIDTH-1:0];
        end else begin
            o_result = w_q[SAMPLE_WIDTH-1:0];
        end
    end

endmodule

### sv/decimating_iq_fir_filter.sv
// A push that completes a decimation period runs a pass over the taps in use through
// FETCH, LOAD, MAC and DONE, one 16x4 digit product per cycle per channel, and no
// input is taken until it ends. Other pushes and coefficient loads leave the block idle.
// The result register lets the next input transfer while a result waits.
// Reset is synchronous and active low; rings and taps read as zero through per-entry
// valid flags, so no clearing pass follows reset.
module decimating_iq_fir_filter
    import dfir_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_item          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_item         o_out_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CFG_AW-1:0] i_cfg_index,
    input  logic [CFG_DW-1:0] i_cfg_data
);

    t_state                r_state, n_state;
    logic [TAP_AW-1:0]     r_wp, n_wp;
    logic [PHASE_W-1:0]    r_phase, n_phase;
    logic [TAP_AW-1:0]     r_start, n_start;
    logic [TAP_AW-1:0]     r_fk, n_fk;
    logic [TAP_AW-1:0]     r_k, n_k;
    logic [DIG_AW-1:0]     r_dig, n_dig;
    logic [TAPCNT_W-1:0]   r_tap_count;
    logic [DEC_W-1:0]      r_dec;
    logic [MODE_W-1:0]     r_mode;
    logic                  r_oval, n_oval;
    t_out_item             r_out;

    logic [TAPCNT_W-1:0]   w_ntap;
    logic [DEC_W-1:0]      w_dec;
    logic                  w_in_xfer;
    logic                  w_push, w_load, w_fire;
    logic                  w_use_i, w_use_q;
    logic                  w_out_wr;
    logic [TAP_AW-1:0]     w_last_k;
    t_mac_ctl              w_ctl;

    logic signed [SAMPLE_WIDTH-1:0] w_ring_i, w_ring_q, w_tap_i, w_tap_q;
    logic signed [SAMPLE_WIDTH-1:0] w_res_i, w_res_q;
    logic [TAP_AW-1:0]              w_ring_addr;

    always_comb begin
        if (r_tap_count == '0) begin
            w_ntap = TAPCNT_W'(1);
        end else if (r_tap_count > TAPCNT_W'(MAX_TAPS)) begin
            w_ntap = TAPCNT_W'(MAX_TAPS);
        end else begin
            w_ntap = r_tap_count;
        end
        if (r_dec == '0) begin
            w_dec = DEC_W'(1);
        end else if (r_dec > DEC_W'(MAX_DECIMATION)) begin
            w_dec = DEC_W'(MAX_DECIMATION);
        end else begin
            w_dec = r_dec;
        end
    end

    assign w_last_k    = TAP_AW'(w_ntap - TAPCNT_W'(1));
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_in_xfer   = i_in_valid && o_in_ready;
    assign w_push      = w_in_xfer && (i_in_data.action == ACT_PUSH);
    assign w_load      = w_in_xfer && (i_in_data.action == ACT_LOAD);
    assign w_fire      = !(({1'b0, r_phase} + DEC_W'(1)) < w_dec);
    assign w_use_i     = (r_mode != MODE_Q_ONLY);
    assign w_use_q     = (r_mode != MODE_I_ONLY);
    assign w_ring_addr = r_start + r_fk;

    always_comb begin
        n_state     = r_state;
        n_wp        = r_wp;
        n_phase     = r_phase;
        n_start     = r_start;
        n_fk        = r_fk;
        n_k         = r_k;
        n_dig       = r_dig;
        n_oval      = r_oval;
        w_out_wr    = 1'b0;
        w_ctl       = '0;
        w_ctl.dig   = r_dig;
        if (o_out_valid && i_out_ready) begin
            n_oval = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (w_push) begin
                    n_wp = r_wp + TAP_AW'(1);
                    if (w_fire) begin
                        n_phase = '0;
                        n_start = r_wp + TAP_AW'(1) - w_ntap[TAP_AW-1:0];
                        n_fk    = '0;
                        n_state = S_FETCH;
                    end else begin
                        n_phase = r_phase + PHASE_W'(1);
                    end
                end
            end
            S_FETCH: begin
                w_ctl.clr = 1'b1;
                n_fk      = r_fk + TAP_AW'(1);
                n_state   = S_LOAD;
            end
            S_LOAD: begin
                w_ctl.load = 1'b1;
                n_k        = '0;
                n_dig      = '0;
                n_state    = S_MAC;
            end
            S_MAC: begin
                w_ctl.step = 1'b1;
                n_dig      = r_dig + DIG_AW'(1);
                if (r_dig == DIG_AW'(N_DIGITS - 1)) begin
                    if (r_k == w_last_k) begin
                        n_state = S_DONE;
                    end else begin
                        w_ctl.load = 1'b1;
                        n_k        = r_k + TAP_AW'(1);
                        n_fk       = r_fk + TAP_AW'(1);
                    end
                end
            end
            S_DONE: begin
                if (!r_oval || i_out_ready) begin
                    w_out_wr = 1'b1;
                    n_oval   = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp        <= '0;
            r_phase     <= '0;
            r_oval      <= 1'b0;
            r_tap_count <= TAPCNT_W'(MAX_TAPS);
            r_dec       <= DEC_W'(1);
            r_mode      <= MODE_COMPLEX;
        end else begin
            r_wp    <= n_wp;
            r_phase <= n_phase;
            r_oval  <= n_oval;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_TAP_COUNT:    r_tap_count <= i_cfg_data[TAPCNT_W-1:0];
                    CFG_DECIMATION:   r_dec       <= i_cfg_data[DEC_W-1:0];
                    CFG_CHANNEL_MODE: r_mode      <= i_cfg_data[MODE_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_start <= n_start;
        r_fk    <= n_fk;
        r_k     <= n_k;
        r_dig   <= n_dig;
        if (w_out_wr) begin
            r_out.out_i <= w_use_i ? w_res_i : '0;
            r_out.out_q <= w_use_q ? w_res_q : '0;
        end
    end

    assign o_out_valid = r_oval;
    assign o_out_data  = r_out;

    dfir_store u_ring_i (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_push && w_use_i),
        .i_waddr (r_wp),
        .i_wdata (i_in_data.sample_i),
        .i_raddr (w_ring_addr),
        .o_rdata (w_ring_i)
    );

    dfir_store u_ring_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_push && w_use_q),
        .i_waddr (r_wp),
        .i_wdata (i_in_data.sample_q),
        .i_raddr (w_ring_addr),
        .o_rdata (w_ring_q)
    );

    dfir_store u_taps_i (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_load),
        .i_waddr (i_in_data.tap_index[TAP_AW-1:0]),
        .i_wdata (i_in_data.coef_i),
        .i_raddr (r_fk),
        .o_rdata (w_tap_i)
    );

    dfir_store u_taps_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_load),
        .i_waddr (i_in_data.tap_index[TAP_AW-1:0]),
        .i_wdata (i_in_data.coef_q),
        .i_raddr (r_fk),
        .o_rdata (w_tap_q)
    );

    dfir_mac u_mac_i (
        .i_clk    (i_clk),
        .i_ctl    (w_ctl),
        .i_sample (w_ring_i),
        .i_coef   (w_tap_i),
        .o_result (w_res_i)
    );

    dfir_mac u_mac_q (
        .i_clk    (i_clk),
        .i_ctl    (w_ctl),
        .i_sample (w_ring_q),
        .i_coef   (w_tap_q),
        .o_result (w_res_q)
    );

`ifndef SYNTH
    a_fire_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && w_fire) |=> (r_state == S_FETCH))
        else $error("A completed decimation period did not start a pass.");

    a_load_to_mac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD) |=> (r_state == S_MAC))
        else $error("Operand load was not followed by the digit steps.");

    a_tap_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MAC) |-> (r_k <= w_last_k))
        else $error("Tap counter ran past the taps in use.");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("A waiting result was lost or overwritten.");
`endif

endmodule
